@@ hdl/esc_pkg.sv @@
// Shared types, constants and small helper functions for the epoch-seconds
// to calendar converter. No dependencies.
package esc_pkg;

   // Divisor selection for the shared constant divider
   localparam logic [1:0] DIV_SEL_DAY  = 2'd0;
   localparam logic [1:0] DIV_SEL_HOUR = 2'd1;
   localparam logic [1:0] DIV_SEL_MIN  = 2'd2;

   localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECONDS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECONDS_PER_MIN  = 17'd60;

   // Reciprocals for the odd factor of each divisor:
   // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
   // q = (x * RECIP) >> SHIFT is exact over the dividend width used.
   localparam logic [24:0] DAY_RECIP  = 25'd25451659;   // ceil(2^34 / 675)
   localparam logic [13:0] HOUR_RECIP = 14'd9321;       // ceil(2^21 / 225)
   localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)

   localparam logic [10:0] EPOCH_YEAR    = 11'd1970;
   localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
   localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
   localparam logic [6:0]  LAST_MOD100   = 7'd99;
   localparam logic [8:0]  LAST_MOD400   = 9'd399;
   localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;   // 1970-01-01 was a Thursday
   localparam logic [8:0]  DAYS_COMMON   = 9'd365;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;
   localparam logic [3:0]  MONTH_FEB     = 4'd1;
   localparam logic [3:0]  MONTH_DEC     = 4'd11;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

   typedef struct packed {
      logic       load;       // start a new item
      logic       div_en;     // one divider step
      logic [1:0] div_sel;
      logic       div_rem;    // multiply back and subtract; else store quotient
      logic       year_step;
      logic       month_step;
      logic       publish;    // load the output register
   } esc_cmd_type;

   typedef struct packed {
      logic year_fits;
      logic month_done;
   } esc_status_type;

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd31;
      endcase
      return len;
   endfunction

   // Month length modulo 7: how far the weekday advances over the month
   function automatic logic [1:0] month_shift(input logic [3:0] mon, input logic leap);
      logic [1:0] sh;
      case (month_days(mon, leap))
         5'd31:   sh = 2'd3;
         5'd30:   sh = 2'd2;
         5'd29:   sh = 2'd1;
         default: sh = 2'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [2:0] mod7_small(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      for (int i = 0; i < 5; i++) begin
         if (r >= 6'(DAYS_PER_WEEK)) r = r - 6'(DAYS_PER_WEEK);
      end
      return r[2:0];
   endfunction

endpackage

@@ hdl/esc_datapath.sv @@
// Datapath: constant dividers by reciprocal multiplication, year and month
// counting loops and the result register. Depends on esc_pkg.
module esc_datapath (
   input  logic                   clock,
   input  logic [30:0]            epoch_seconds,
   input  esc_pkg::esc_cmd_type   cmd,
   output esc_pkg::esc_status_type status,
   output logic [5:0]             second_of_minute,
   output logic [5:0]             minute_of_hour,
   output logic [4:0]             hour_of_day,
   output logic [2:0]             weekday,
   output logic [4:0]             day_of_month,
   output logic [3:0]             month_number,
   output logic [10:0]            year_number
);
   import esc_pkg::*;

   logic [30:0] rem_ff, rem_in;
   logic [14:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [2:0]  wd_ff, wd_in;
   logic [10:0] year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  mon_ff, mon_in;

   logic [5:0]  out_sec_ff, out_min_ff;
   logic [4:0]  out_hour_ff, out_day_ff;
   logic [2:0]  out_wd_ff;
   logic [3:0]  out_mon_ff;
   logic [10:0] out_year_ff;

   logic [48:0] day_prod;
   logic [26:0] hour_prod;
   logic [20:0] min_prod;
   logic [30:0] back_prod;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mlen;
   logic [3:0]  wd_sum;

   always_comb begin
      // Quotients: strip the power-of-two factor, then multiply by the reciprocal
      day_prod  = 49'(rem_ff[30:7]) * 49'(DAY_RECIP);
      hour_prod = 27'(rem_ff[16:4]) * 27'(HOUR_RECIP);
      min_prod  = 21'(rem_ff[11:2]) * 21'(MIN_RECIP);

      case (cmd.div_sel)
         DIV_SEL_DAY:  back_prod = 31'(days_ff) * 31'(SECONDS_PER_DAY);
         DIV_SEL_HOUR: back_prod = 31'(hour_ff) * 31'(SECONDS_PER_HOUR);
         default:      back_prod = 31'(min_ff) * 31'(SECONDS_PER_MIN);
      endcase

      leap     = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
      year_len = leap ? DAYS_LEAP : DAYS_COMMON;
      mlen     = month_days(mon_ff, leap);

      status.year_fits  = days_ff < 15'(year_len);
      status.month_done = (days_ff < 15'(mlen)) || (mon_ff == MONTH_DEC);
   end

   always_comb begin
      rem_in    = rem_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      min_in    = min_ff;
      sec_in    = sec_ff;
      wd_in     = wd_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      mon_in    = mon_ff;
      wd_sum    = 4'd0;

      if (cmd.load) begin
         rem_in    = epoch_seconds;
         wd_in     = EPOCH_WEEKDAY;
         year_in   = EPOCH_YEAR;
         mod4_in   = EPOCH_MOD4;
         mod100_in = EPOCH_MOD100;
         mod400_in = EPOCH_MOD400;
         mon_in    = '0;
      end else if (cmd.div_en) begin
         if (!cmd.div_rem) begin
            case (cmd.div_sel)
               DIV_SEL_DAY:  days_in = day_prod[48:34];
               DIV_SEL_HOUR: hour_in = hour_prod[25:21];
               default:      min_in  = min_prod[19:14];
            endcase
         end else begin
            rem_in = rem_ff - back_prod;
            if (cmd.div_sel == DIV_SEL_MIN) sec_in = rem_in[5:0];
         end
      end else if (cmd.year_step && !status.year_fits) begin
         days_in   = days_ff - 15'(year_len);
         year_in   = year_ff + 11'd1;
         mod4_in   = mod4_ff + 2'd1;
         mod100_in = (mod100_ff == LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
         mod400_in = (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
         wd_sum    = {1'b0, wd_ff} + (leap ? 4'd2 : 4'd1);
         wd_in     = (wd_sum >= 4'(DAYS_PER_WEEK)) ? 3'(wd_sum - 4'(DAYS_PER_WEEK))
                                                   : wd_sum[2:0];
      end else if (cmd.month_step && !status.month_done) begin
         days_in = days_ff - 15'(mlen);
         mon_in  = mon_ff + 4'd1;
         wd_sum  = {1'b0, wd_ff} + {2'b00, month_shift(mon_ff, leap)};
         wd_in   = (wd_sum >= 4'(DAYS_PER_WEEK)) ? 3'(wd_sum - 4'(DAYS_PER_WEEK))
                                                 : wd_sum[2:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      sec_ff    <= sec_in;
      wd_ff     <= wd_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mon_ff    <= mon_in;
   end

   // Result register: holds while the next item is being worked on
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_sec_ff  <= sec_ff;
         out_min_ff  <= min_ff;
         out_hour_ff <= hour_ff;
         out_wd_ff   <= mod7_small({3'b000, wd_ff} + {1'b0, days_ff[4:0]});
         out_day_ff  <= days_ff[4:0] + 5'd1;
         out_mon_ff  <= mon_ff + 4'd1;
         out_year_ff <= year_ff;
      end
   end

   assign second_of_minute = out_sec_ff;
   assign minute_of_hour   = out_min_ff;
   assign hour_of_day      = out_hour_ff;
   assign weekday          = out_wd_ff;
   assign day_of_month     = out_day_ff;
   assign month_number     = out_mon_ff;
   assign year_number      = out_year_ff;

endmodule

@@ hdl/esc_ctrl.sv @@
// Controller: sequences the division steps, year and month loops, and owns
// the input and result handshakes. Depends on esc_pkg.
module esc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  esc_pkg::esc_status_type status,
   output esc_pkg::esc_cmd_type   cmd
);
   import esc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVDAY = 3'd1;
   localparam logic [2:0] ST_DIVHR  = 3'd2;
   localparam logic [2:0] ST_DIVMIN = 3'd3;
   localparam logic [2:0] ST_YEAR   = 3'd4;
   localparam logic [2:0] ST_MONTH  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic       valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               phase_in = 1'b0;
               state_in = ST_DIVDAY;
            end
         end
         ST_DIVDAY, ST_DIVHR, ST_DIVMIN: begin
            // quotient step first, then the remainder step
            cmd.div_en  = 1'b1;
            cmd.div_sel = (state_ff == ST_DIVDAY) ? DIV_SEL_DAY :
                          (state_ff == ST_DIVHR)  ? DIV_SEL_HOUR : DIV_SEL_MIN;
            cmd.div_rem = phase_ff;
            phase_in    = !phase_ff;
            if (phase_ff) begin
               if (state_ff == ST_DIVDAY) begin
                  state_in = ST_DIVHR;
               end else if (state_ff == ST_DIVHR) begin
                  state_in = ST_DIVMIN;
               end else begin
                  state_in = ST_YEAR;
               end
            end
         end
         ST_YEAR: begin
            cmd.year_step = 1'b1;
            if (status.year_fits) state_in = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (status.month_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait until the result register is free
            if (!valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   ctrl_publish_frees : assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   ctrl_div_exclusive : assert property (@(posedge clock) disable iff (reset)
      cmd.div_en |-> !(cmd.load || cmd.year_step || cmd.month_step || cmd.publish))
      else $error("divider step overlaps another command");

   ctrl_load_only_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIVDAY) && !phase_ff)
      else $error("load did not start the day division");

endmodule

@@ hdl/epoch_seconds_to_calendar_unit.sv @@
// Top level of the epoch-seconds to calendar converter: joins the controller
// and the datapath. Depends on esc_pkg, esc_ctrl and esc_datapath.
//
// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, weekday (0 = Sunday), day of month, month and year. One item
// is worked on at a time: an accept step, constant division for days, hours
// and minutes in turn (a reciprocal multiply for the quotient and a
// multiply-subtract for the remainder), a year loop that takes off one year
// length per elapsed year, a month loop that does the same for the months of
// the final year, and a publish step; the year loop sets most of the time
// per item. A finished result sits in an output register, so the next item
// may be accepted while it waits; the publish of that next item holds until
// the waiting result has been taken.
module epoch_seconds_to_calendar_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] epoch_seconds, [31] zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
   // [19:17] weekday, [24:20] day_of_month, [28:25] month_number,
   // [39:29] year_number
   output logic [39:0] rsp_tdata
);
   import esc_pkg::*;

   esc_cmd_type    cmd;
   esc_status_type status;
   logic [5:0]     second_of_minute, minute_of_hour;
   logic [4:0]     hour_of_day, day_of_month;
   logic [2:0]     weekday;
   logic [3:0]     month_number;
   logic [10:0]    year_number;

   esc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   esc_datapath u_datapath (
      .clock            (clock),
      .epoch_seconds    (req_tdata[30:0]),
      .cmd              (cmd),
      .status           (status),
      .second_of_minute (second_of_minute),
      .minute_of_hour   (minute_of_hour),
      .hour_of_day      (hour_of_day),
      .weekday          (weekday),
      .day_of_month     (day_of_month),
      .month_number     (month_number),
      .year_number      (year_number)
   );

   assign rsp_tdata = {year_number, month_number, day_of_month, weekday,
                       hour_of_day, minute_of_hour, second_of_minute};

   top_month_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (month_number != 4'd0) && (month_number <= 4'd12))
      else $error("month out of range");

   top_day_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (day_of_month != 5'd0))
      else $error("day of month is zero");

   top_time_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hour_of_day < 5'd24) && (minute_of_hour < 6'd60)
                     && (second_of_minute < 6'd60) && (weekday < 3'd7))
      else $error("time of day or weekday out of range");

endmodule

@@ tb/tb_top.sv @@
// Testbench for epoch_seconds_to_calendar_unit: converts random and boundary
// timestamps and checks every date against an in-house calendar predictor.
// Depends only on the RTL under hdl/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 150;
   localparam int unsigned SECS_PER_DAY = 86400;
   localparam logic [30:0] LAST_EPOCH   = 31'h7FFF_FFFF;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                               31, 31, 30, 31, 30, 31};

   // Same layout as rsp_tdata, second_of_minute in the lowest bits
   typedef struct packed {
      logic [10:0] year_number;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
      logic [2:0]  weekday;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
   } calendar_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [30:0] epoch_seconds, [31] zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
   // [19:17] weekday, [24:20] day_of_month, [28:25] month_number,
   // [39:29] year_number
   logic [39:0] rsp_tdata;

   calendar_t   expected_dates [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned stall_left  = 0;

   epoch_seconds_to_calendar_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned days_before_year(input int unsigned yr);
      int unsigned total;
      total = 0;
      for (int unsigned y = 1970; y < yr; y++) total += is_leap_year(y) ? 366 : 365;
      return total;
   endfunction

   function automatic calendar_t predict_calendar(input logic [30:0] secs);
      calendar_t   date;
      int unsigned t, days, yr, mon, len;
      t = 32'(secs);
      date.second_of_minute = 6'(t % 60);
      t = t / 60;
      date.minute_of_hour = 6'(t % 60);
      t = t / 60;
      date.hour_of_day = 5'(t % 24);
      days = t / 24;
      date.weekday = 3'((days + 4) % 7);   // the epoch fell on a Thursday
      yr = 1970;
      len = is_leap_year(yr) ? 366 : 365;
      while (days >= len) begin
         days -= len;
         yr++;
         len = is_leap_year(yr) ? 366 : 365;
      end
      // December takes whatever is left of the year
      mon = 0;
      len = MONTH_DAYS[0];
      while (mon < 11 && days >= len) begin
         days -= len;
         mon++;
         len = (mon == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[mon];
      end
      date.day_of_month = 5'(days + 1);
      date.month_number = 4'(mon + 1);
      date.year_number  = 11'(yr);
      return date;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps
   task automatic send_epoch(input logic [30:0] secs);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, secs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_dates.push_back(predict_calendar(secs));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   task automatic test_directed();
      logic [30:0] stamps [$];
      stamps = '{31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399,
                 31'd86400,
                 31'd31449600,     // last day of a common year
                 31'd68169600,     // leap day 1972
                 31'd68256000,     // March 1 after a leap day
                 31'd94608000,     // day 366 of 1972
                 31'd94694399,     // last second of a leap year
                 31'd94694400,
                 31'd951782400,    // leap day of a century leap year
                 31'd978220800,    // last day of 2000
                 31'd978307200,
                 31'd2145916800,   // start of 2038
                 LAST_EPOCH,
                 31'h2AAA_AAAA, 31'h5555_5555};
      foreach (stamps[i]) send_epoch(stamps[i]);
   endtask

   task automatic test_uniform(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == count / 2) wait_for_results();
         send_epoch(31'($urandom()));
      end
   endtask

   // Aim mostly at day, month and year boundaries where carries ripple, mixed with random days
   task automatic test_calendar_edges(input int unsigned count);
      longint unsigned secs;
      int unsigned     yr, year_start, day, offset;
      for (int unsigned i = 0; i < count; i++) begin
         yr = $urandom_range(1970, 2038);
         year_start = days_before_year(yr);
         case ($urandom_range(0, 3))
            0:       day = $urandom_range(0, 24855);
            1:       day = (yr == 1970) ? 0 : year_start - $urandom_range(0, 1);
            2:       day = year_start + $urandom_range(27, 60);
            default: day = year_start + $urandom_range(330, 365);
         endcase
         case ($urandom_range(0, 2))
            0:       offset = 0;
            1:       offset = SECS_PER_DAY - 1;
            default: offset = $urandom_range(0, SECS_PER_DAY - 1);
         endcase
         secs = longint'(day) * SECS_PER_DAY + offset;
         if (secs > LAST_EPOCH) secs = 64'(LAST_EPOCH) - 64'($urandom_range(0, 3));
         send_epoch(secs[30:0]);
      end
   endtask

   // Receiver: ready pattern changes with bits [13:12] of the cycle count
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         case (cycle_count[13:12])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left <= stall_left - 1;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 100);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      calendar_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_dates.size() == 0) begin
            $error("result transfer with no pending input, rsp_tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            check_field("second_of_minute", 32'(want.second_of_minute),
                        32'(got.second_of_minute));
            check_field("minute_of_hour", 32'(want.minute_of_hour),
                        32'(got.minute_of_hour));
            check_field("hour_of_day", 32'(want.hour_of_day), 32'(got.hour_of_day));
            check_field("weekday", 32'(want.weekday), 32'(got.weekday));
            check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
            check_field("month_number", 32'(want.month_number), 32'(got.month_number));
            check_field("year_number", 32'(want.year_number), 32'(got.year_number));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_for_results();
      test_uniform(300);
      wait_for_results();
      test_calendar_edges(300);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/esc_pkg.sv
hdl/esc_datapath.sv
hdl/esc_ctrl.sv
hdl/epoch_seconds_to_calendar_unit.sv
tb/tb_top.sv
